[hdl/pat2d_pkg.sv]
// ----------------------------------------------------------------------------
// pat2d_pkg
// Shared widths, register map, mode codes and item types of the 2-D point
// translate / rotate / scale block.
// ----------------------------------------------------------------------------
`default_nettype none

package pat2d_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int TRIG_WIDTH  = 16;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 5;

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = DIFF_W + TRIG_WIDTH;
	localparam int NUM_W  = PROD_W + 1;
	localparam int RES_W  = NUM_W + 1;

	localparam int ROT_SHIFT   = 14;
	localparam int SCALE_SHIFT = 8;

	localparam logic signed [TRIG_WIDTH-1:0] COS_RESET   = TRIG_WIDTH'(16384);
	localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET   = '0;
	localparam logic signed [TRIG_WIDTH-1:0] SCALE_RESET = TRIG_WIDTH'(256);

	typedef enum logic [1:0] {
		MODE_TRANSLATE = 2'd0,
		MODE_ROTATE    = 2'd1,
		MODE_SCALE     = 2'd2,
		MODE_PASS      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_REF_X = 3'd1,
		REG_REF_Y = 3'd2,
		REG_COS   = 3'd3,
		REG_SIN   = 3'd4,
		REG_SCALE = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic                          last_point;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] out_x;
		logic signed [COORD_WIDTH-1:0] out_y;
		logic                          last_out;
	} point_out_t;

endpackage

`default_nettype wire

[hdl/point_affine_transform_2d.sv]
// ----------------------------------------------------------------------------
// point_affine_transform_2d
// Six-stage pipeline that translates, rotates, scales or passes through one vertex per cycle while not stalled.
// ----------------------------------------------------------------------------
// Accepts one vertex every clock while the result channel does not stall and
// returns its transformed position through the six-stage pipeline (difference,
// multiply, sum, truncating shift, reference add, saturate).
// A stall on the result channel freezes the whole pipeline and is passed back
// to the vertex channel while the output register holds an item. Products are
// truncated toward zero and results saturate to the signed coordinate range.
// Write the registers over APB only while no item is in flight.
`default_nettype none

module point_affine_transform_2d (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pat2d_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pat2d_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pat2d_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready,
	input  wire logic                             pt_valid,
	output logic                                  pt_stall,
	input  wire pat2d_pkg::point_in_t             pt_data,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output pat2d_pkg::point_out_t                 res_data
);
	import pat2d_pkg::*;

	localparam int W = COORD_WIDTH;

	mode_t                        mode_q;
	logic signed [W-1:0]          ref_x_q;
	logic signed [W-1:0]          ref_y_q;
	logic signed [TRIG_WIDTH-1:0] cos_q;
	logic signed [TRIG_WIDTH-1:0] sin_q;
	logic signed [TRIG_WIDTH-1:0] scale_q;

	logic       cfg_wr;
	reg_index_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_index_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TRANSLATE;
			ref_x_q <= '0;
			ref_y_q <= '0;
			cos_q   <= COS_RESET;
			sin_q   <= SIN_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MODE:  mode_q  <= mode_t'(pwdata[1:0]);
				REG_REF_X: ref_x_q <= pwdata[W-1:0];
				REG_REF_Y: ref_y_q <= pwdata[W-1:0];
				REG_COS:   cos_q   <= pwdata[TRIG_WIDTH-1:0];
				REG_SIN:   sin_q   <= pwdata[TRIG_WIDTH-1:0];
				REG_SCALE: scale_q <= pwdata[TRIG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MODE:  prdata = APB_DATA_W'({mode_q});
			REG_REF_X: prdata = APB_DATA_W'(ref_x_q);
			REG_REF_Y: prdata = APB_DATA_W'(ref_y_q);
			REG_COS:   prdata = APB_DATA_W'(cos_q);
			REG_SIN:   prdata = APB_DATA_W'(sin_q);
			REG_SCALE: prdata = APB_DATA_W'(scale_q);
			default:   prdata = '0;
		endcase
	end

	// pipeline control
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign en       = !(vld_s6 && res_stall);
	assign pt_stall = vld_s6 && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pt_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// stage 1: offsets from the reference and translate sums
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, tx_s1, ty_s1;
	logic signed [W-1:0]      px_s1, py_s1;
	logic                     last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DIFF_W'($signed(pt_data.point_x)) - DIFF_W'(ref_x_q);
			dy_s1   <= DIFF_W'($signed(pt_data.point_y)) - DIFF_W'(ref_y_q);
			tx_s1   <= DIFF_W'($signed(pt_data.point_x)) + DIFF_W'(ref_x_q);
			ty_s1   <= DIFF_W'($signed(pt_data.point_y)) + DIFF_W'(ref_y_q);
			px_s1   <= pt_data.point_x;
			py_s1   <= pt_data.point_y;
			last_s1 <= pt_data.last_point;
		end
	end

	// stage 2: products
	logic signed [PROD_W-1:0] xc_s2, ys_s2, xs_s2, yc_s2, xk_s2, yk_s2;
	logic signed [DIFF_W-1:0] tx_s2, ty_s2;
	logic signed [W-1:0]      px_s2, py_s2;
	logic                     last_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s2   <= PROD_W'(dx_s1) * PROD_W'(cos_q);
			ys_s2   <= PROD_W'(dy_s1) * PROD_W'(sin_q);
			xs_s2   <= PROD_W'(dx_s1) * PROD_W'(sin_q);
			yc_s2   <= PROD_W'(dy_s1) * PROD_W'(cos_q);
			xk_s2   <= PROD_W'(dx_s1) * PROD_W'(scale_q);
			yk_s2   <= PROD_W'(dy_s1) * PROD_W'(scale_q);
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: combine products per mode
	logic signed [NUM_W-1:0] num_x_c, num_y_c;
	logic signed [NUM_W-1:0] num_x_s3, num_y_s3;
	logic                    last_s3;

	always_comb begin
		case (mode_q)
			MODE_TRANSLATE: begin
				num_x_c = NUM_W'(tx_s2);
				num_y_c = NUM_W'(ty_s2);
			end
			MODE_ROTATE: begin
				num_x_c = NUM_W'(xc_s2) - NUM_W'(ys_s2);
				num_y_c = NUM_W'(xs_s2) + NUM_W'(yc_s2);
			end
			MODE_SCALE: begin
				num_x_c = NUM_W'(xk_s2);
				num_y_c = NUM_W'(yk_s2);
			end
			default: begin
				num_x_c = NUM_W'(px_s2);
				num_y_c = NUM_W'(py_s2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s3 <= num_x_c;
			num_y_s3 <= num_y_c;
			last_s3  <= last_s2;
		end
	end

	// stage 4: shift with truncation toward zero
	localparam logic signed [NUM_W-1:0] ROT_BIAS   = NUM_W'((1 << ROT_SHIFT) - 1);
	localparam logic signed [NUM_W-1:0] SCALE_BIAS = NUM_W'((1 << SCALE_SHIFT) - 1);
	localparam logic signed [NUM_W-1:0] NO_BIAS    = '0;

	logic signed [NUM_W-1:0] q_x_c, q_y_c;
	logic signed [NUM_W-1:0] q_x_s4, q_y_s4;
	logic                    last_s4;

	always_comb begin
		case (mode_q)
			MODE_ROTATE: begin
				q_x_c = (num_x_s3 + (num_x_s3[NUM_W-1] ? ROT_BIAS : NO_BIAS)) >>> ROT_SHIFT;
				q_y_c = (num_y_s3 + (num_y_s3[NUM_W-1] ? ROT_BIAS : NO_BIAS)) >>> ROT_SHIFT;
			end
			MODE_SCALE: begin
				q_x_c = (num_x_s3 + (num_x_s3[NUM_W-1] ? SCALE_BIAS : NO_BIAS)) >>> SCALE_SHIFT;
				q_y_c = (num_y_s3 + (num_y_s3[NUM_W-1] ? SCALE_BIAS : NO_BIAS)) >>> SCALE_SHIFT;
			end
			default: begin
				q_x_c = num_x_s3;
				q_y_c = num_y_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_x_s4  <= q_x_c;
			q_y_s4  <= q_y_c;
			last_s4 <= last_s3;
		end
	end

	// stage 5: add the reference back in rotate and scale modes
	logic                    add_ref;
	logic signed [RES_W-1:0] r_x_s5, r_y_s5;
	logic                    last_s5;

	assign add_ref = (mode_q == MODE_ROTATE) || (mode_q == MODE_SCALE);

	always_ff @(posedge clk) begin
		if (en) begin
			r_x_s5  <= RES_W'(q_x_s4) + (add_ref ? RES_W'(ref_x_q) : '0);
			r_y_s5  <= RES_W'(q_y_s4) + (add_ref ? RES_W'(ref_y_q) : '0);
			last_s5 <= last_s4;
		end
	end

	// stage 6: saturate into the output register
	function automatic logic signed [W-1:0] sat(input logic signed [RES_W-1:0] v);
		logic ovf;
		ovf = !((&v[RES_W-1:W-1]) || !(|v[RES_W-1:W-1]));
		if (!ovf)
			sat = v[W-1:0];
		else if (v[RES_W-1])
			sat = {1'b1, {(W-1){1'b0}}};
		else
			sat = {1'b0, {(W-1){1'b1}}};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			res_data.out_x    <= sat(r_x_s5);
			res_data.out_y    <= sat(r_y_s5);
			res_data.last_out <= last_s5;
		end
	end

	assign res_valid = vld_s6;

endmodule

`default_nettype wire
